// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/plsm_pkg.sv =====
`default_nettype none
package plsm_pkg;

    localparam int NUM_CH          = 7;
    localparam int CHECKED_CH      = 4;
    localparam int LOCK_W          = 7;
    localparam int CHAN_W          = 3;
    localparam int OUT_W           = 32;
    localparam int LIMIT_W         = 31;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 31;
    localparam int DEF_COUNT_WIDTH = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_READ_LIMIT_EN  = 2'd0,
        REG_READ_LIMIT     = 2'd1,
        REG_ERROR_LIMIT_EN = 2'd2,
        REG_ERROR_LIMIT    = 2'd3
    } t_reg_idx;

    // control broadcast to every counter cell
    typedef struct packed {
        logic inc;    // a sample is taken this cycle
        logic load;   // report fires: snapshot into the report chain, clear counters
        logic shift;  // report chain advances by one cell
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== design/plsm_smp_if.sv =====
`default_nettype none
interface plsm_smp_if;
    import plsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [LOCK_W-1:0] lock_bits;

    modport source (output valid, output lock_bits, input ready);
    modport sink   (input valid, input lock_bits, output ready);

endinterface
`default_nettype wire

// ===== design/plsm_rpt_if.sv =====
`default_nettype none
interface plsm_rpt_if;
    import plsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  sample_total;
    logic [CHAN_W-1:0] channel;
    logic [OUT_W-1:0]  locked_count;
    logic [OUT_W-1:0]  unlocked_count;
    logic              last_item;

    modport source (output valid, output sample_total, output channel, output locked_count,
                    output unlocked_count, output last_item, input ready);
    modport sink   (input valid, input sample_total, input channel, input locked_count,
                    input unlocked_count, input last_item, output ready);

endinterface
`default_nettype wire

// ===== design/plsm_sat_out.sv =====
`default_nettype none
module plsm_sat_out #(
    parameter int COUNT_WIDTH = plsm_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic [COUNT_WIDTH-1:0]     i_count,
    output logic      [plsm_pkg::OUT_W-1:0] o_count
);
    import plsm_pkg::*;

    generate
        if (COUNT_WIDTH > OUT_W) begin : g_clip
            // counts beyond the report width read as all ones
            assign o_count = (|i_count[COUNT_WIDTH-1:OUT_W]) ? {OUT_W{1'b1}}
                                                            : i_count[OUT_W-1:0];
        end else begin : g_ext
            assign o_count = OUT_W'(i_count);
        end
    endgenerate

endmodule
`default_nettype wire

// ===== design/plsm_cell.sv =====
`default_nettype none
module plsm_cell #(
    parameter int COUNT_WIDTH = plsm_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire plsm_pkg::t_cell_ctrl           i_ctrl,
    input  wire logic                           i_bit,
    input  wire logic [plsm_pkg::OUT_W-1:0]     i_prev_locked,
    input  wire logic [plsm_pkg::OUT_W-1:0]     i_prev_unlocked,
    output logic      [COUNT_WIDTH-1:0]         o_unlocked_next,
    output logic      [plsm_pkg::OUT_W-1:0]     o_rpt_locked,
    output logic      [plsm_pkg::OUT_W-1:0]     o_rpt_unlocked
);
    import plsm_pkg::*;

    logic [COUNT_WIDTH-1:0] r_locked;
    logic [COUNT_WIDTH-1:0] r_unlocked;
    logic [COUNT_WIDTH-1:0] n_locked;
    logic [COUNT_WIDTH-1:0] n_unlocked;
    logic [OUT_W-1:0]       r_rpt_locked;
    logic [OUT_W-1:0]       r_rpt_unlocked;
    logic [OUT_W-1:0]       w_sat_locked;
    logic [OUT_W-1:0]       w_sat_unlocked;

    // saturating increment of whichever counter the sample bit selects
    always_comb begin
        n_locked   = r_locked;
        n_unlocked = r_unlocked;
        if (i_bit) begin
            if (r_locked != {COUNT_WIDTH{1'b1}}) n_locked = r_locked + 1'b1;
        end else begin
            if (r_unlocked != {COUNT_WIDTH{1'b1}}) n_unlocked = r_unlocked + 1'b1;
        end
    end

    assign o_unlocked_next = n_unlocked;

    plsm_sat_out #(.COUNT_WIDTH(COUNT_WIDTH)) u_sat_locked (
        .i_count (n_locked),
        .o_count (w_sat_locked)
    );

    plsm_sat_out #(.COUNT_WIDTH(COUNT_WIDTH)) u_sat_unlocked (
        .i_count (n_unlocked),
        .o_count (w_sat_unlocked)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked   <= '0;
            r_unlocked <= '0;
        end else if (i_ctrl.load) begin
            r_locked   <= '0;
            r_unlocked <= '0;
        end else if (i_ctrl.inc) begin
            r_locked   <= n_locked;
            r_unlocked <= n_unlocked;
        end
    end

    // report chain stage: loaded on a report, then handed on towards the top cell
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rpt_locked   <= w_sat_locked;
            r_rpt_unlocked <= w_sat_unlocked;
        end else if (i_ctrl.shift) begin
            r_rpt_locked   <= i_prev_locked;
            r_rpt_unlocked <= i_prev_unlocked;
        end
    end

    assign o_rpt_locked   = r_rpt_locked;
    assign o_rpt_unlocked = r_rpt_unlocked;

endmodule
`default_nettype wire

// ===== design/pll_lock_statistics_monitor.sv =====
// channel  | dir | handshake         | payload
// i_smp    | in  | valid / ready     | lock_bits
// o_rpt    | out | valid / ready     | sample_total, channel, locked_count,
//          |     |                   | unlocked_count, last_item
// i_cfg_*  | in  | we, no back-press | addr, data
//
// A sample is counted in the cycle it is accepted; one sample per clock while ready.
// A sample that trips a limit loads the seven-cell report chain in that same cycle;
// the chain then drains one transaction per cycle, while o_rpt.ready is high, from
// the channel 6 cell. While a report is held in the chain i_smp.ready is low, so no
// sample is accepted until the last of the seven transactions is taken.
// Synchronous reset clears all counters and control registers; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module pll_lock_statistics_monitor #(
    parameter int COUNT_WIDTH = plsm_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    plsm_smp_if.sink                                 i_smp,
    plsm_rpt_if.source                               o_rpt,
    input  wire logic                                i_cfg_we,
    input  wire logic [plsm_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [plsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import plsm_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic               r_rd_en;
    logic [LIMIT_W-1:0] r_rd_lim;
    logic               r_er_en;
    logic [LIMIT_W-1:0] r_er_lim;

    logic [COUNT_WIDTH-1:0] r_sample;
    logic [COUNT_WIDTH-1:0] n_sample;
    logic [OUT_W-1:0]       w_sample_sat;
    logic [OUT_W-1:0]       r_rpt_total;
    logic [CHAN_W-1:0]      r_rpt_left;

    logic                   w_accept;
    logic                   w_shift;
    logic                   w_fire_rd;
    logic                   w_fire_er;
    logic                   w_fire;
    t_cell_ctrl             w_ctrl;

    logic [COUNT_WIDTH-1:0] w_unl_next [NUM_CH];
    logic [OUT_W-1:0]       w_rpt_locked [NUM_CH];
    logic [OUT_W-1:0]       w_rpt_unlocked [NUM_CH];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en  <= 1'b0;
            r_rd_lim <= '0;
            r_er_en  <= 1'b0;
            r_er_lim <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_READ_LIMIT_EN:  r_rd_en  <= i_cfg_data[0];
                REG_READ_LIMIT:     r_rd_lim <= i_cfg_data[LIMIT_W-1:0];
                REG_ERROR_LIMIT_EN: r_er_en  <= i_cfg_data[0];
                REG_ERROR_LIMIT:    r_er_lim <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_smp.ready = (r_rpt_left == '0);
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign w_shift     = o_rpt.valid && o_rpt.ready;

    assign n_sample = (r_sample == {COUNT_WIDTH{1'b1}}) ? r_sample : r_sample + 1'b1;

    assign w_fire_rd = r_rd_en && (CMP_W'(n_sample) >= CMP_W'(r_rd_lim));

    always_comb begin
        w_fire_er = 1'b0;
        for (int c = 0; c < CHECKED_CH; c++) begin
            if (CMP_W'(w_unl_next[c]) >= CMP_W'(r_er_lim)) w_fire_er = 1'b1;
        end
        w_fire_er = w_fire_er && r_er_en;
    end

    assign w_fire      = w_accept && (w_fire_rd || w_fire_er);
    assign w_ctrl.inc   = w_accept;
    assign w_ctrl.load  = w_fire;
    assign w_ctrl.shift = w_shift;

    generate
        for (genvar g = 0; g < NUM_CH; g++) begin : g_cell
            logic [OUT_W-1:0] w_prev_locked;
            logic [OUT_W-1:0] w_prev_unlocked;
            if (g == 0) begin : g_head
                assign w_prev_locked   = '0;
                assign w_prev_unlocked = '0;
            end else begin : g_link
                assign w_prev_locked   = w_rpt_locked[g-1];
                assign w_prev_unlocked = w_rpt_unlocked[g-1];
            end
            plsm_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_ctrl          (w_ctrl),
                .i_bit           (i_smp.lock_bits[g]),
                .i_prev_locked   (w_prev_locked),
                .i_prev_unlocked (w_prev_unlocked),
                .o_unlocked_next (w_unl_next[g]),
                .o_rpt_locked    (w_rpt_locked[g]),
                .o_rpt_unlocked  (w_rpt_unlocked[g])
            );
        end
    endgenerate

    plsm_sat_out #(.COUNT_WIDTH(COUNT_WIDTH)) u_sat_total (
        .i_count (n_sample),
        .o_count (w_sample_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample   <= '0;
            r_rpt_left <= '0;
        end else begin
            if (w_fire) begin
                r_sample   <= '0;
                r_rpt_left <= CHAN_W'(NUM_CH);
            end else begin
                if (w_accept) r_sample <= n_sample;
                if (w_shift)  r_rpt_left <= r_rpt_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) r_rpt_total <= w_sample_sat;
    end

    // while a report is held, the top cell holds the channel numbered one below the items left
    assign o_rpt.valid          = (r_rpt_left != '0);
    assign o_rpt.sample_total   = r_rpt_total;
    assign o_rpt.channel        = r_rpt_left - 1'b1;
    assign o_rpt.locked_count   = w_rpt_locked[NUM_CH-1];
    assign o_rpt.unlocked_count = w_rpt_unlocked[NUM_CH-1];
    assign o_rpt.last_item      = (r_rpt_left == CHAN_W'(1));

    `ASSERT_CLK(a_no_accept_in_report, i_clk, i_rst_n, (r_rpt_left != '0) |-> !w_accept, "sample accepted while a report is held")
    `ASSERT_CLK(a_fire_loads_and_clears, i_clk, i_rst_n, w_fire |=> ((r_rpt_left == CHAN_W'(NUM_CH)) && (r_sample == '0)), "report fire did not load the chain and clear the count")
    `ASSERT_CLK(a_last_frees_input, i_clk, i_rst_n, (w_shift && o_rpt.last_item) |=> (i_smp.ready && !o_rpt.valid), "input not released after the last report transaction")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import plsm_pkg::*;

    localparam int COUNT_W        = DEF_COUNT_WIDTH;
    localparam int LONG_HOLD      = 100;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef logic [COUNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [OUT_W-1:0]  total;
        logic [CHAN_W-1:0] chan;
        logic [OUT_W-1:0]  locked;
        logic [OUT_W-1:0]  unlocked;
        logic              last;
    } t_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    plsm_smp_if smp_if ();
    plsm_rpt_if rpt_if ();

    pll_lock_statistics_monitor u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_if),
        .o_rpt      (rpt_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    // statistics predictor state
    bit                 rd_limit_en;
    logic [LIMIT_W-1:0] rd_limit;
    bit                 err_limit_en;
    logic [LIMIT_W-1:0] err_limit;
    t_cnt               smp_count;
    t_cnt               lock_count   [NUM_CH];
    t_cnt               unlock_count [NUM_CH];

    logic [LOCK_W-1:0] pending_samples[$];
    t_report           expected_reports[$];

    bit failed       = 1'b0;
    bit smp_taken    = 1'b0;
    bit quiet_run    = 1'b0;
    bit rpt_hold_go  = 1'b0;
    bit rpt_hold_done = 1'b0;
    int smp_gap      = 0;
    int rpt_gap      = 0;
    int rpt_hold_left = 0;
    int idle_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] clip_count(input t_cnt v);
        if (COUNT_W > OUT_W && v > t_cnt'({OUT_W{1'b1}}))
            return '1;
        return OUT_W'(v);
    endfunction

    task automatic tally_lock_sample(input logic [LOCK_W-1:0] bits);
        bit      trip;
        int      c;
        t_report r;
        trip = 1'b0;
        smp_count = sat_inc(smp_count);
        for (c = 0; c < NUM_CH; c++) begin
            if (bits[c])
                lock_count[c] = sat_inc(lock_count[c]);
            else
                unlock_count[c] = sat_inc(unlock_count[c]);
        end
        if (rd_limit_en && smp_count >= t_cnt'(rd_limit))
            trip = 1'b1;
        if (err_limit_en) begin
            for (c = 0; c < CHECKED_CH; c++) begin
                if (unlock_count[c] >= t_cnt'(err_limit))
                    trip = 1'b1;
            end
        end
        if (trip) begin
            // burst runs from the highest channel down to channel 0
            for (c = NUM_CH - 1; c >= 0; c--) begin
                r.total    = clip_count(smp_count);
                r.chan     = CHAN_W'(c);
                r.locked   = clip_count(lock_count[c]);
                r.unlocked = clip_count(unlock_count[c]);
                r.last     = (c == 0);
                expected_reports.push_back(r);
            end
            smp_count = '0;
            for (c = 0; c < NUM_CH; c++) begin
                lock_count[c]   = '0;
                unlock_count[c] = '0;
            end
        end
    endtask

    task automatic check_report();
        t_report want;
        if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report transaction, channel %0d total %0d",
                     $time, rpt_if.channel, rpt_if.sample_total);
            failed = 1'b1;
        end else begin
            want = expected_reports.pop_front();
            if (rpt_if.sample_total !== want.total) begin
                $display("%0t: sample_total expected %0d actual %0d",
                         $time, want.total, rpt_if.sample_total);
                failed = 1'b1;
            end
            if (rpt_if.channel !== want.chan) begin
                $display("%0t: channel expected %0d actual %0d",
                         $time, want.chan, rpt_if.channel);
                failed = 1'b1;
            end
            if (rpt_if.locked_count !== want.locked) begin
                $display("%0t: locked_count (ch %0d) expected %0d actual %0d",
                         $time, want.chan, want.locked, rpt_if.locked_count);
                failed = 1'b1;
            end
            if (rpt_if.unlocked_count !== want.unlocked) begin
                $display("%0t: unlocked_count (ch %0d) expected %0d actual %0d",
                         $time, want.chan, want.unlocked, rpt_if.unlocked_count);
                failed = 1'b1;
            end
            if (rpt_if.last_item !== want.last) begin
                $display("%0t: last_item (ch %0d) expected %0b actual %0b",
                         $time, want.chan, want.last, rpt_if.last_item);
                failed = 1'b1;
            end
        end
    endtask

    // monitor: register writes, accepted samples and report transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_taken <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_READ_LIMIT_EN:  rd_limit_en  = cfg_data[0];
                    REG_READ_LIMIT:     rd_limit     = cfg_data[LIMIT_W-1:0];
                    REG_ERROR_LIMIT_EN: err_limit_en = cfg_data[0];
                    REG_ERROR_LIMIT:    err_limit    = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            smp_taken <= smp_if.valid && smp_if.ready;
            if (smp_if.valid && smp_if.ready)
                tally_lock_sample(smp_if.lock_bits);
            if (rpt_if.valid && rpt_if.ready)
                check_report();
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else if (smp_if.valid && !smp_taken) begin
            // hold the offered transaction until it is taken
        end else if (smp_gap > 0) begin
            smp_gap      <= smp_gap - 1;
            smp_if.valid <= 1'b0;
        end else if (pending_samples.size() == 0) begin
            smp_if.valid <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
            smp_gap      <= $urandom_range(0, 16);
            smp_if.valid <= 1'b0;
        end else begin
            smp_if.valid     <= 1'b1;
            smp_if.lock_bits <= pending_samples.pop_front();
        end
    end

    // report receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rpt_if.ready <= 1'b0;
        end else if (rpt_hold_go && !rpt_hold_done) begin
            rpt_hold_done <= 1'b1;
            rpt_hold_left <= LONG_HOLD - 1;
            rpt_if.ready  <= 1'b0;
        end else if (rpt_hold_left > 0) begin
            rpt_hold_left <= rpt_hold_left - 1;
            rpt_if.ready  <= 1'b0;
        end else if (rpt_gap > 0) begin
            rpt_gap      <= rpt_gap - 1;
            rpt_if.ready <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
            rpt_gap      <= $urandom_range(0, 16);
            rpt_if.ready <= 1'b0;
        end else begin
            rpt_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("pll_lock_statistics_monitor test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // checked at the rising edge, where the driver's last update has settled
    task automatic wait_drained();
        while (pending_samples.size() != 0 || smp_if.valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // enable registers get random upper bits, only bit 0 should count
    task automatic set_limits(input bit rd_en, input logic [LIMIT_W-1:0] rd_lim,
                              input bit er_en, input logic [LIMIT_W-1:0] er_lim);
        logic [CFG_DATA_W-1:0] en_word;
        wait_drained();
        en_word    = CFG_DATA_W'($urandom);
        en_word[0] = rd_en;
        cfg_write(REG_READ_LIMIT_EN, en_word);
        cfg_write(REG_READ_LIMIT, rd_lim);
        en_word    = CFG_DATA_W'($urandom);
        en_word[0] = er_en;
        cfg_write(REG_ERROR_LIMIT_EN, en_word);
        cfg_write(REG_ERROR_LIMIT, er_lim);
        @(posedge i_clk);
    endtask

    function automatic logic [LOCK_W-1:0] random_lock_bits();
        case ($urandom_range(0, 9))
            0:          return '0;
            1, 2, 3, 4: return LOCK_W'($urandom_range(0, 127));
            5:          return '1;
            // healthy plant with one pll dropping out
            default:    return ~(LOCK_W'(1) << $urandom_range(0, LOCK_W - 1));
        endcase
    endfunction

    initial begin
        int  ph;
        int  i;
        bit  rd_en;
        bit  er_en;
        smp_if.valid     = 1'b0;
        smp_if.lock_bits = '0;
        rpt_if.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_addr         = '0;
        cfg_data         = '0;
        i_rst_n          = 1'b0;
        rd_limit_en      = 1'b0;
        rd_limit         = '0;
        err_limit_en     = 1'b0;
        err_limit        = '0;
        smp_count        = '0;
        for (i = 0; i < NUM_CH; i++) begin
            lock_count[i]   = '0;
            unlock_count[i] = '0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both triggers off after reset: counts only accumulate
        @(posedge i_clk);
        pending_samples.push_back(7'h00);
        pending_samples.push_back(7'h7F);
        for (i = 0; i < LOCK_W; i++)
            pending_samples.push_back(LOCK_W'(1) << i);

        // read limit of zero reports on every sample
        set_limits(1'b1, '0, 1'b0, '0);
        pending_samples.push_back(7'h55);
        pending_samples.push_back(7'h2A);
        pending_samples.push_back(7'h7F);

        // error limit of zero reports on every sample
        set_limits(1'b0, '0, 1'b1, '0);
        pending_samples.push_back(7'h0F);
        pending_samples.push_back(7'h70);

        // phy channels never trip the error limit, ddr0 and ppc do
        set_limits(1'b0, '0, 1'b1, 31'd2);
        pending_samples.push_back(7'h0F);
        pending_samples.push_back(7'h0F);
        pending_samples.push_back(7'h0F);
        pending_samples.push_back(7'h0E);
        pending_samples.push_back(7'h0E);
        pending_samples.push_back(7'h77);
        pending_samples.push_back(7'h77);

        // largest limits are never reached
        set_limits(1'b1, '1, 1'b1, '1);
        pending_samples.push_back(7'h00);
        pending_samples.push_back(7'h00);

        for (ph = 0; ph < 8; ph++) begin
            rd_en = $urandom_range(0, 1);
            er_en = rd_en ? $urandom_range(0, 1) : 1'b1;
            if (ph == 2)
                set_limits(1'b0, LIMIT_W'($urandom_range(0, 15)), 1'b0,
                           LIMIT_W'($urandom_range(0, 8)));
            else if (ph == 4)
                set_limits(1'b1, 31'd2, 1'b0, '0);
            else
                set_limits(rd_en, LIMIT_W'($urandom_range(0, 15)), er_en,
                           LIMIT_W'($urandom_range(0, 8)));
            // receiver holds off while samples keep coming
            if (ph == 4)
                rpt_hold_go = 1'b1;
            for (i = 0; i < 36; i++)
                pending_samples.push_back(random_lock_bits());
        end

        set_limits(1'b1, 31'd5, 1'b1, 31'd3);
        quiet_run = 1'b1;
        for (i = 0; i < 24; i++)
            pending_samples.push_back(random_lock_bits());

        wait_drained();
        repeat (16) @(negedge i_clk);
        if (!failed)
            $display("pll_lock_statistics_monitor test passed");
        else
            $display("pll_lock_statistics_monitor test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/plsm_pkg.sv
design/plsm_smp_if.sv
design/plsm_rpt_if.sv
design/plsm_sat_out.sv
design/plsm_cell.sv
design/pll_lock_statistics_monitor.sv
tb/sv/testbench.sv
